/* src/reprojection_error_gate_macros.svh */
// Assertion macros shared by the reprojection error gate RTL.
`ifndef REPROJECTION_ERROR_GATE_MACROS_SVH
`define REPROJECTION_ERROR_GATE_MACROS_SVH

// Check that a condition implies an expression in the same cycle.
`define RPE_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define RPE_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* src/rpe_pkg.sv */
// Types, constants and codes of the reprojection error gate.
`default_nettype none

package rpe_pkg;

    // Quotient format: integer bits, fraction bits, signed width with clamp value
    localparam int INT_BITS  = 5;
    localparam int FRAC_BITS = 28;
    localparam int QBITS     = INT_BITS + FRAC_BITS;
    localparam int QW        = QBITS + 2;

    // Datapath widths
    localparam int COORD_W = 32;
    localparam int ENTRY_W = 16;
    localparam int PROD_W  = COORD_W + ENTRY_W;
    localparam int TRANS_W = ENTRY_W + 24;
    localparam int PW      = PROD_W + 2;
    localparam int ERR_W   = 32;

    // Pipeline latencies and sideband taps
    localparam int XF_LAT   = 2;
    localparam int DIV_LAT  = QBITS + 3;
    localparam int SQ_LAT   = 3;
    localparam int SB_DEPTH = XF_LAT + DIV_LAT + SQ_LAT;
    localparam int IDX_DIV  = XF_LAT - 1;
    localparam int IDX_SQ   = XF_LAT - 1 + DIV_LAT;
    localparam int IDX_LAST = SB_DEPTH - 1;

    // Register indexes
    localparam logic [1:0] CFG_POSE_A = 2'd0;
    localparam logic [1:0] CFG_POSE_B = 2'd1;
    localparam logic [1:0] CFG_POSE_C = 2'd2;
    localparam logic [1:0] CFG_LIMIT  = 2'd3;

    // Register reset values
    localparam logic [63:0]      POSE_A_RST = 64'd4096;
    localparam logic [63:0]      POSE_B_RST = 64'd4096 << 16;
    localparam logic [63:0]      POSE_C_RST = 64'd4096 << 32;
    localparam logic [ERR_W-1:0] LIMIT_RST  = 32'd16777216;

    typedef enum logic [1:0] {
        VERDICT_KEEP     = 2'd0,
        VERDICT_SKIP     = 2'd1,
        VERDICT_REF_FAIL = 2'd2,
        VERDICT_CUR_FAIL = 2'd3
    } verdict_t;

    typedef logic [2:0][63:0] pose_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] ref_u;
        logic signed [31:0] ref_v;
        logic signed [31:0] cur_u;
        logic signed [31:0] cur_v;
        logic               in_inlier;
    } point_t;

    typedef struct packed {
        logic        keep;
        verdict_t    verdict;
        logic [31:0] ref_error;
        logic [31:0] cur_error;
    } result_t;

endpackage

`default_nettype wire

/* src/rpe_div.sv */
// Pipelined restoring divider giving a signed Q5.28 quotient, one bit per stage.
`default_nettype none

module rpe_div #(
    parameter int W = rpe_pkg::COORD_W
) (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic signed [W-1:0]            num,
    input  wire logic signed [W-1:0]            den,
    output logic signed [rpe_pkg::QW-1:0]       quo,
    output logic                                den_zero
);

    localparam int QB = rpe_pkg::QBITS;
    localparam int IB = rpe_pkg::INT_BITS;
    localparam int QW = rpe_pkg::QW;

    logic [W-1:0]  num_u;
    logic [W-1:0]  den_u;
    logic [W-1:0]  un_next;
    logic [W-1:0]  ud_next;
    logic [W-1:0]  un_reg;
    logic [W-1:0]  ud_reg;
    logic          neg_reg;
    logic          dz_reg;
    logic [W-1:0]  top_part;

    logic [W-1:0]  rem_reg   [QB+1];
    logic [QB-1:0] q_reg     [QB+1];
    logic [W-1:0]  ud_p      [QB+1];
    logic          neg_p     [QB+1];
    logic          dz_p      [QB+1];
    logic          clamp_p   [QB+1];
    logic [IB-1:0] low_p     [QB+1];

    logic [QB:0]   qmag;
    logic [QW-1:0] qext;
    logic [QW-1:0] quo_next;
    logic [QW-1:0] quo_reg;
    logic          dz_out_reg;

    // Take magnitudes and the quotient sign
    assign num_u   = num;
    assign den_u   = den;
    assign un_next = num_u[W-1] ? (~num_u + W'(1)) : num_u;
    assign ud_next = den_u[W-1] ? (~den_u + W'(1)) : den_u;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un_reg  <= un_next;
            ud_reg  <= ud_next;
            neg_reg <= num_u[W-1] ^ den_u[W-1];
            dz_reg  <= (den_u == '0);
        end
    end

    // Seed the remainder with the dividend above the integer bits; detect clamp
    assign top_part = un_reg >> IB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= top_part;
            q_reg[0]   <= '0;
            ud_p[0]    <= ud_reg;
            neg_p[0]   <= neg_reg;
            dz_p[0]    <= dz_reg;
            clamp_p[0] <= (top_part >= ud_reg);
            low_p[0]   <= un_reg[IB-1:0];
        end
    end

    // One quotient bit per stage
    for (genvar s = 0; s < QB; s++)
    begin : g_step
        logic         bit_in;
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic         ge;

        if (s < IB)
        begin : g_low
            assign bit_in = low_p[s][IB-1-s];
        end
        else
        begin : g_zero
            assign bit_in = 1'b0;
        end

        assign trial = {rem_reg[s], bit_in};
        assign diff  = trial - {1'b0, ud_p[s]};
        assign ge    = (trial >= {1'b0, ud_p[s]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? diff[W-1:0] : trial[W-1:0];
                q_reg[s+1]   <= {q_reg[s][QB-2:0], ge};
                ud_p[s+1]    <= ud_p[s];
                neg_p[s+1]   <= neg_p[s];
                dz_p[s+1]    <= dz_p[s];
                clamp_p[s+1] <= clamp_p[s];
                low_p[s+1]   <= low_p[s];
            end
        end
    end

    // Apply clamp and sign
    assign qmag     = clamp_p[QB] ? ((QB+1)'(1) << QB) : {1'b0, q_reg[QB]};
    assign qext     = QW'(qmag);
    assign quo_next = neg_p[QB] ? (~qext + QW'(1)) : qext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg    <= quo_next;
            dz_out_reg <= dz_p[QB];
        end
    end

    assign quo      = quo_reg;
    assign den_zero = dz_out_reg;

endmodule

`default_nettype wire

/* src/rpe_sqerr.sv */
// Squared error of two Q4.28 differences in saturating Q8.24, three stages.
`default_nettype none

module rpe_sqerr (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [31:0]                feat_u,
    input  wire logic signed [31:0]                feat_v,
    input  wire logic signed [rpe_pkg::QW-1:0]     quo_u,
    input  wire logic signed [rpe_pkg::QW-1:0]     quo_v,
    input  wire logic                              zero_in,
    output logic [rpe_pkg::ERR_W-1:0]              err,
    output logic                                   sat,
    output logic                                   zero_out
);

    localparam int DW = rpe_pkg::QW + 1;

    logic signed [DW-1:0] diff   [2];
    logic        [DW-1:0] mag    [2];
    logic        [31:0]   mag_reg [2];
    logic                 big_reg [2];
    logic        [63:0]   sq_reg  [2];
    logic                 big2_reg [2];
    logic        [32:0]   sum;
    logic                 sat_next;
    logic        [31:0]   err_reg;
    logic                 sat_reg;
    logic        [2:0]    zero_reg;

    // Form the differences and their magnitudes
    always_comb
    begin
        diff[0] = DW'(feat_u) - DW'(quo_u);
        diff[1] = DW'(feat_v) - DW'(quo_v);
        for (int k = 0; k < 2; k++)
        begin
            mag[k] = diff[k][DW-1] ? (~diff[k] + DW'(1)) : diff[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                mag_reg[k] <= mag[k][31:0];
                big_reg[k] <= |mag[k][DW-1:32];
            end
        end
    end

    // Square each magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                sq_reg[k]   <= 64'(mag_reg[k]) * 64'(mag_reg[k]);
                big2_reg[k] <= big_reg[k];
            end
        end
    end

    // Add the Q8.24 terms and saturate
    assign sum      = 33'(sq_reg[0][63:32]) + 33'(sq_reg[1][63:32]);
    assign sat_next = big2_reg[0] | big2_reg[1] | sum[32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg  <= sat_next ? '1 : sum[31:0];
            sat_reg  <= sat_next;
            zero_reg <= {zero_reg[1:0], zero_in};
        end
    end

    assign err      = err_reg;
    assign sat      = sat_reg;
    assign zero_out = zero_reg[2];

endmodule

`default_nettype wire

/* src/rpe_xform.sv */
// Pose transform of the 3D point into the current frame, Q.36, two stages.
`default_nettype none

module rpe_xform (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire rpe_pkg::point_t               point,
    input  wire rpe_pkg::pose_t                pose,
    output logic signed [rpe_pkg::PW-1:0]      px,
    output logic signed [rpe_pkg::PW-1:0]      py,
    output logic signed [rpe_pkg::PW-1:0]      pz
);

    localparam int PROD_W  = rpe_pkg::PROD_W;
    localparam int TRANS_W = rpe_pkg::TRANS_W;
    localparam int PW      = rpe_pkg::PW;

    logic signed [31:0]        coord    [3];
    logic signed [15:0]        ent      [3][4];
    logic signed [PROD_W-1:0]  prod_next [3][3];
    logic signed [TRANS_W-1:0] trans_next [3];
    logic signed [PROD_W-1:0]  prod_reg  [3][3];
    logic signed [TRANS_W-1:0] trans_reg [3];
    logic signed [PW-1:0]      p_next    [3];
    logic signed [PW-1:0]      p_reg     [3];

    // Multiply rotation entries by the coordinates, scale the translation
    always_comb
    begin
        coord[0] = point.point_x;
        coord[1] = point.point_y;
        coord[2] = point.point_z;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                ent[i][j] = pose[i][16*j +: 16];
            end
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = ent[i][j] * coord[j];
            end
            trans_next[i] = {ent[i][3], 24'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
        end
    end

    // Sum each row
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = PW'(prod_reg[i][0]) + PW'(prod_reg[i][1])
                      + PW'(prod_reg[i][2]) + PW'(trans_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign px = p_reg[0];
    assign py = p_reg[1];
    assign pz = p_reg[2];

endmodule

`default_nettype wire

/* src/reprojection_error_gate.sv */
// Top level of the reprojection error gate: registers, pipeline and verdict.
//
//  channel  | handshake                  | beat
//  ---------+----------------------------+-------------------------------
//  point    | point_valid / point_stall  | point_data (rpe_pkg::point_t)
//  result   | result_valid / result_stall| result_data (rpe_pkg::result_t)
//  config   | cfg_we                     | cfg_index, cfg_data
//
//  One point enters per cycle while point_stall is low; it passes the pose
//  transform, the dividers' 33-stage quotient pipeline and the squarers.
//  Reset clears all valid bits and loads the identity pose and a limit of 1.0.
//  A held result beat freezes the whole pipeline; point_stall follows it.
`default_nettype none

module reprojection_error_gate (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              point_valid,
    output logic                   point_stall,
    input  wire rpe_pkg::point_t   point_data,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output rpe_pkg::result_t       result_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data
);

    localparam int SB_DEPTH = rpe_pkg::SB_DEPTH;
    localparam int QW       = rpe_pkg::QW;
    localparam int PW       = rpe_pkg::PW;

    logic [63:0]               pose_a_reg;
    logic [63:0]               pose_b_reg;
    logic [63:0]               pose_c_reg;
    logic [31:0]               limit_reg;
    rpe_pkg::pose_t            pose;

    logic                      adv;
    logic [SB_DEPTH-1:0]       vld_reg;
    rpe_pkg::point_t           pt_reg [SB_DEPTH];
    rpe_pkg::point_t           pt_div;
    rpe_pkg::point_t           pt_sq;
    rpe_pkg::point_t           pt_last;

    logic signed [PW-1:0]      px;
    logic signed [PW-1:0]      py;
    logic signed [PW-1:0]      pz;
    logic signed [QW-1:0]      rq_u;
    logic signed [QW-1:0]      rq_v;
    logic signed [QW-1:0]      cq_u;
    logic signed [QW-1:0]      cq_v;
    logic                      ref_dz;
    logic                      cur_dz;
    logic [31:0]               ref_err;
    logic [31:0]               cur_err;
    logic                      ref_sat;
    logic                      cur_sat;
    logic                      ref_zero;
    logic                      cur_zero;

    rpe_pkg::result_t          result_next;
    rpe_pkg::result_t          result_reg;
    logic                      result_valid_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_a_reg <= rpe_pkg::POSE_A_RST;
            pose_b_reg <= rpe_pkg::POSE_B_RST;
            pose_c_reg <= rpe_pkg::POSE_C_RST;
            limit_reg  <= rpe_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rpe_pkg::CFG_POSE_A: pose_a_reg <= cfg_data;
                rpe_pkg::CFG_POSE_B: pose_b_reg <= cfg_data;
                rpe_pkg::CFG_POSE_C: pose_c_reg <= cfg_data;
                rpe_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[31:0];
            endcase
        end
    end

    assign pose = {pose_c_reg, pose_b_reg, pose_a_reg};

    // Advance everything unless a result beat is held
    assign adv         = !(result_valid_reg && result_stall);
    assign point_stall = !adv;

    // Valid bits travel along the sideband line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[SB_DEPTH-2:0], point_valid};
        end
    end

    // Carry the input beat alongside the datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg[0] <= point_data;
            for (int k = 1; k < SB_DEPTH; k++)
            begin
                pt_reg[k] <= pt_reg[k-1];
            end
        end
    end

    assign pt_div  = pt_reg[rpe_pkg::IDX_DIV];
    assign pt_sq   = pt_reg[rpe_pkg::IDX_SQ];
    assign pt_last = pt_reg[rpe_pkg::IDX_LAST];

    rpe_xform u_xform (
        .clk   (clk),
        .en    (adv),
        .point (point_data),
        .pose  (pose),
        .px    (px),
        .py    (py),
        .pz    (pz)
    );

    rpe_div #(.W(rpe_pkg::COORD_W)) u_div_ref_u (
        .clk      (clk),
        .en       (adv),
        .num      (pt_div.point_x),
        .den      (pt_div.point_z),
        .quo      (rq_u),
        .den_zero (ref_dz)
    );

    rpe_div #(.W(rpe_pkg::COORD_W)) u_div_ref_v (
        .clk      (clk),
        .en       (adv),
        .num      (pt_div.point_y),
        .den      (pt_div.point_z),
        .quo      (rq_v),
        .den_zero ()
    );

    rpe_div #(.W(PW)) u_div_cur_u (
        .clk      (clk),
        .en       (adv),
        .num      (px),
        .den      (pz),
        .quo      (cq_u),
        .den_zero (cur_dz)
    );

    rpe_div #(.W(PW)) u_div_cur_v (
        .clk      (clk),
        .en       (adv),
        .num      (py),
        .den      (pz),
        .quo      (cq_v),
        .den_zero ()
    );

    rpe_sqerr u_sq_ref (
        .clk      (clk),
        .en       (adv),
        .feat_u   (pt_sq.ref_u),
        .feat_v   (pt_sq.ref_v),
        .quo_u    (rq_u),
        .quo_v    (rq_v),
        .zero_in  (ref_dz),
        .err      (ref_err),
        .sat      (ref_sat),
        .zero_out (ref_zero)
    );

    rpe_sqerr u_sq_cur (
        .clk      (clk),
        .en       (adv),
        .feat_u   (pt_sq.cur_u),
        .feat_v   (pt_sq.cur_v),
        .quo_u    (cq_u),
        .quo_v    (cq_v),
        .zero_in  (cur_dz),
        .err      (cur_err),
        .sat      (cur_sat),
        .zero_out (cur_zero)
    );

    // Decide the verdict in check order
    always_comb
    begin
        result_next.keep      = 1'b0;
        result_next.verdict   = rpe_pkg::VERDICT_KEEP;
        result_next.ref_error = ref_err;
        result_next.cur_error = '0;
        priority if (!pt_last.in_inlier)
        begin
            result_next.verdict   = rpe_pkg::VERDICT_SKIP;
            result_next.ref_error = '0;
        end
        else if (ref_zero)
        begin
            result_next.verdict   = rpe_pkg::VERDICT_REF_FAIL;
            result_next.ref_error = '1;
        end
        else if (ref_sat || (ref_err > limit_reg))
        begin
            result_next.verdict = rpe_pkg::VERDICT_REF_FAIL;
        end
        else if (cur_zero)
        begin
            result_next.verdict   = rpe_pkg::VERDICT_CUR_FAIL;
            result_next.cur_error = '1;
        end
        else if (cur_sat || (cur_err > limit_reg))
        begin
            result_next.verdict   = rpe_pkg::VERDICT_CUR_FAIL;
            result_next.cur_error = cur_err;
        end
        else
        begin
            result_next.keep      = 1'b1;
            result_next.cur_error = cur_err;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= vld_reg[rpe_pkg::IDX_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`include "reprojection_error_gate_macros.svh"

    `RPE_ASSERT_IMP(a_skip_clean,
        result_valid_reg && result_reg.verdict == rpe_pkg::VERDICT_SKIP,
        result_reg.ref_error == '0 && result_reg.cur_error == '0 && !result_reg.keep,
        "skipped point carries nonzero errors")
    `RPE_ASSERT_IMP(a_keep_within,
        result_valid_reg && result_reg.verdict == rpe_pkg::VERDICT_KEEP,
        result_reg.keep && result_reg.ref_error <= limit_reg
            && result_reg.cur_error <= limit_reg,
        "kept point exceeds the error limit")
    `RPE_ASSERT_IMP(a_ref_fail_no_cur,
        result_valid_reg && result_reg.verdict == rpe_pkg::VERDICT_REF_FAIL,
        result_reg.cur_error == '0 && !result_reg.keep,
        "reference failure reports a current error")
    `RPE_ASSERT_NEXT(a_stall_freeze,
        result_valid_reg && result_stall,
        $stable(vld_reg),
        "pipeline moved while a result beat was held")

endmodule

`default_nettype wire
